// ----- hw/rtl/assert_macros.svh -----
// ---------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers shared by the drawing engine modules.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Property must hold at every clock edge outside reset.
`define ASSERT_CLK(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");
// Condition must never be true outside reset.
`define ASSERT_NEVER(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("forbidden condition seen");
`else
`define ASSERT_CLK(lbl, clk, rst_n, prop)
`define ASSERT_NEVER(lbl, clk, rst_n, cond)
`endif
`endif

// ----- hw/rtl/fbde_pkg.sv -----
// ---------------------------------------------------------------------------
// fbde_pkg
// Geometry, command codes and shared types of the page framebuffer engine.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package fbde_pkg;

  // Picture geometry. Storage is column major, PAGES page bytes per column.
  localparam int COLUMNS = 128;
  localparam int ROWS    = 64;
  localparam int PAGES   = (ROWS + 7) / 8;
  localparam int DEPTH   = COLUMNS * PAGES;
  localparam int ADDR_W  = $clog2(DEPTH);

  // Command queue between front and back.
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);

  typedef enum logic [2:0] {
    KIND_PIXEL = 3'd0,
    KIND_HLINE = 3'd1,
    KIND_VLINE = 3'd2,
    KIND_RECT  = 3'd3,
    KIND_CLEAR = 3'd4,
    KIND_READ  = 3'd5
  } kind_e;

  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] x_start;
    logic [7:0] y_start;
    logic [7:0] x_end;
    logic [7:0] y_end;
  } cmd_t;

  typedef struct packed {
    logic [7:0] read_byte;
    logic       out_of_range;
  } result_t;

  // Operations carried by the queue. Lines are already clipped and non-empty.
  typedef enum logic [2:0] {
    OP_HLINE,
    OP_VLINE,
    OP_CLEAR,
    OP_READ,
    OP_READ_OOR
  } op_e;

  // fix: row of a horizontal line, column of a vertical line or read.
  // lo/hi: first and last position along the line; lo is the read row.
  typedef struct packed {
    op_e        code;
    logic [7:0] fix;
    logic [7:0] lo;
    logic [7:0] hi;
  } op_t;

  typedef enum logic {
    FR_ACCEPT,
    FR_RECT
  } fr_state_e;

  typedef enum logic [2:0] {
    BK_INIT,
    BK_IDLE,
    BK_CLEAR,
    BK_HLINE,
    BK_VLINE
  } bk_state_e;

  // One read-modify-write unit of the back end.
  typedef enum logic [1:0] {
    U_DRAW,
    U_CLEAR,
    U_READ,
    U_READ_OOR
  } unit_e;

endpackage

// ----- hw/rtl/page_framebuffer_draw_engine_unit.sv -----
// ---------------------------------------------------------------------------
// page_framebuffer_draw_engine_unit
// Monochrome page framebuffer with pixel, line, rectangle, clear and read.
// ---------------------------------------------------------------------------
//
//  Channel   Direction  Handshake                 Payload
//  in        input      in_valid_i / in_ready_o   in_data_i  (cmd_t)
//  out       output     out_valid_o / out_ready_i out_data_o (result_t)
//
// After reset the page store is cleared one byte a cycle, all DEPTH bytes
// (1024 at 128 by 64); in_ready_o stays low for that time.
// While drawing or clearing, the back end writes one page byte a cycle
// through a read-modify-write pipeline on a RAM with one write and one
// read port: a horizontal line writes one byte per clipped pixel, a vertical
// line one per page touched, a clear every byte, once taken from the queue.
// A rectangle keeps in_ready_o low while the front end queues those of its edges that survive clipping.
// A read passes through the queue, the issue stage, the write-back stage
// and the result register before out_valid_o rises; a result that waits
// for out_ready_i holds the next read at the head of the queue, and with
// it every later transaction, so the input stalls once the queue is full.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module page_framebuffer_draw_engine_unit import fbde_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  input  cmd_t    in_data_i,
  output logic    out_valid_o,
  input  logic    out_ready_i,
  output result_t out_data_o
);

  // The front end clips each command and turns a rectangle into its
  // edges, so every line that the queue holds really draws something.
  logic q_push;
  op_t  q_op;
  logic q_pop;
  op_t  q_head;
  logic q_full;
  logic q_empty;
  logic init_busy;

  fbde_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .init_busy_i(init_busy),
    .q_full_i   (q_full),
    .q_push_o   (q_push),
    .q_op_o     (q_op)
  );

  // The queue lets the front keep taking transactions while the back end
  // works through a long line or a clear.
  fbde_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (q_push),
    .op_i   (q_op),
    .pop_i  (q_pop),
    .head_o (q_head),
    .full_o (q_full),
    .empty_o(q_empty)
  );

  // The back end owns the page store and the result register, which parts
  // the output handshake from the drawing pipeline.
  fbde_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .q_empty_i  (q_empty),
    .q_head_i   (q_head),
    .q_pop_o    (q_pop),
    .init_busy_o(init_busy),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

endmodule

// ----- hw/rtl/fbde_ram.sv -----
// ---------------------------------------------------------------------------
// fbde_ram
// Generic single write, single read RAM with registered read data.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module fbde_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // A read at the address being written returns the old contents.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- hw/rtl/fbde_front.sv -----
// ---------------------------------------------------------------------------
// fbde_front
// Accepts commands, clips them and splits rectangles into four lines.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module fbde_front import fbde_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  cmd_t in_data_i,
  input  logic init_busy_i,
  input  logic q_full_i,
  output logic q_push_o,
  output op_t  q_op_o
);

  localparam logic [8:0] ColLimit = 9'(COLUMNS);
  localparam logic [8:0] RowLimit = 9'(ROWS);
  localparam logic [7:0] ColLast  = 8'(COLUMNS - 1);
  localparam logic [7:0] RowLast  = 8'(ROWS - 1);

  typedef struct packed {
    logic ok;
    op_t  op;
  } job_t;

  // A line is kept only if it has at least one pixel inside the picture.
  function automatic job_t hline_job(logic [7:0] x0, logic [7:0] x1, logic [7:0] y);
    job_t j;
    j         = '0;
    j.op.code = OP_HLINE;
    j.op.fix  = y;
    j.op.lo   = x0;
    j.op.hi   = ({1'b0, x1} < ColLimit) ? x1 : ColLast;
    j.ok      = (x0 <= x1) && ({1'b0, x0} < ColLimit) && ({1'b0, y} < RowLimit);
    return j;
  endfunction

  function automatic job_t vline_job(logic [7:0] x, logic [7:0] y0, logic [7:0] y1);
    job_t j;
    j         = '0;
    j.op.code = OP_VLINE;
    j.op.fix  = x;
    j.op.lo   = y0;
    j.op.hi   = ({1'b0, y1} < RowLimit) ? y1 : RowLast;
    j.ok      = (y0 <= y1) && ({1'b0, y0} < RowLimit) && ({1'b0, x} < ColLimit);
    return j;
  endfunction

  fr_state_e  fr_q, fr_d;
  logic [1:0] phase_q, phase_d;
  cmd_t       rect_q, rect_d;
  job_t       job;
  logic       accept;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fr_q    <= FR_ACCEPT;
      phase_q <= '0;
    end else begin
      fr_q    <= fr_d;
      phase_q <= phase_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rect_q <= rect_d;
  end

  always_comb begin
    fr_d       = fr_q;
    phase_d    = phase_q;
    rect_d     = rect_q;
    job        = '0;
    q_push_o   = 1'b0;
    in_ready_o = (fr_q == FR_ACCEPT) && !q_full_i && !init_busy_i;
    accept     = in_valid_i && in_ready_o;
    if (fr_q == FR_ACCEPT) begin
      unique case (in_data_i.kind)
        KIND_PIXEL: job = hline_job(in_data_i.x_start, in_data_i.x_start, in_data_i.y_start);
        KIND_HLINE: job = hline_job(in_data_i.x_start, in_data_i.x_end, in_data_i.y_start);
        KIND_VLINE: job = vline_job(in_data_i.x_start, in_data_i.y_start, in_data_i.y_end);
        KIND_CLEAR: begin
          job.ok      = 1'b1;
          job.op.code = OP_CLEAR;
        end
        KIND_READ: begin
          job.ok      = 1'b1;
          job.op.fix  = in_data_i.x_start;
          job.op.lo   = in_data_i.y_start;
          job.op.code = (({1'b0, in_data_i.x_start} < ColLimit) &&
                         ({1'b0, in_data_i.y_start} < RowLimit)) ? OP_READ : OP_READ_OOR;
        end
        default: job = '0;
      endcase
      q_push_o = accept && job.ok;
      if (accept && (in_data_i.kind == KIND_RECT)) begin
        fr_d    = FR_RECT;
        phase_d = '0;
        rect_d  = in_data_i;
      end
    end else begin
      unique case (phase_q)
        2'd0: job = hline_job(rect_q.x_start, rect_q.x_end, rect_q.y_start);
        2'd1: job = hline_job(rect_q.x_start, rect_q.x_end, rect_q.y_end);
        2'd2: job = vline_job(rect_q.x_start, rect_q.y_start, rect_q.y_end);
        2'd3: job = vline_job(rect_q.x_end, rect_q.y_start, rect_q.y_end);
      endcase
      q_push_o = job.ok && !q_full_i;
      if (!job.ok || !q_full_i) begin
        phase_d = phase_q + 2'd1;
        if (phase_q == 2'd3) begin
          fr_d = FR_ACCEPT;
        end
      end
    end
  end

  assign q_op_o = job.op;

endmodule

// ----- hw/rtl/fbde_queue.sv -----
// ---------------------------------------------------------------------------
// fbde_queue
// Short first-in first-out queue of operations between front and back.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module fbde_queue import fbde_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  op_t  op_i,
  input  logic pop_i,
  output op_t  head_o,
  output logic full_o,
  output logic empty_o
);

  op_t               mem_q [QDEPTH];
  logic [QPTR_W-1:0] wr_q, rd_q;
  logic [QPTR_W:0]   cnt_q;

  assign full_o  = (cnt_q == (QPTR_W + 1)'(QDEPTH));
  assign empty_o = (cnt_q == '0);
  assign head_o  = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= op_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= wr_q + QPTR_W'(1);
      end
      if (pop_i) begin
        rd_q <= rd_q + QPTR_W'(1);
      end
      unique case ({push_i, pop_i})
        2'b10:   cnt_q <= cnt_q + (QPTR_W + 1)'(1);
        2'b01:   cnt_q <= cnt_q - (QPTR_W + 1)'(1);
        default: cnt_q <= cnt_q;
      endcase
    end
  end

  `ASSERT_NEVER(q_no_overflow, clk_i, rst_ni, push_i && full_o && !pop_i)
  `ASSERT_NEVER(q_no_underflow, clk_i, rst_ni, pop_i && empty_o)

endmodule

// ----- hw/rtl/fbde_back.sv -----
// ---------------------------------------------------------------------------
// fbde_back
// Executes queued operations as read-modify-write units on the page store.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module fbde_back import fbde_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    q_empty_i,
  input  op_t     q_head_i,
  output logic    q_pop_o,
  output logic    init_busy_o,
  output logic    out_valid_o,
  input  logic    out_ready_i,
  output result_t out_data_o
);

  localparam logic [ADDR_W-1:0] AddrLast = ADDR_W'(DEPTH - 1);

  function automatic logic [ADDR_W-1:0] page_addr(logic [7:0] x, logic [4:0] page);
    logic [15:0] full;
    full = 16'(x) * 16'(PAGES) + 16'(page);
    return full[ADDR_W-1:0];
  endfunction

  bk_state_e         st_q, st_d;
  logic [7:0]        cur_q, cur_d, hi_q, hi_d, fix_q, fix_d;
  logic [ADDR_W-1:0] clr_q, clr_d;

  // Issue stage outputs
  logic              a_valid;
  unit_e             a_unit;
  logic [ADDR_W-1:0] a_addr;
  logic [7:0]        a_mask;
  logic              vl_last;
  logic [2:0]        vl_end;
  logic              read_free;

  // Write-back stage
  logic              b_valid_q;
  unit_e             b_unit_q;
  logic [ADDR_W-1:0] b_addr_q;
  logic [7:0]        b_mask_q;
  logic              b_is_read;
  logic              fwd_q;
  logic [7:0]        fwd_data_q;
  logic [7:0]        base;

  logic              ram_we;
  logic [7:0]        ram_wdata;
  logic [7:0]        ram_rdata;

  logic              out_valid_q, out_valid_d;
  result_t           out_q, out_d;

  assign b_is_read = b_valid_q && ((b_unit_q == U_READ) || (b_unit_q == U_READ_OOR));
  assign read_free = !out_valid_q && !b_is_read;
  assign vl_last   = (cur_q[7:3] == hi_q[7:3]);
  assign vl_end    = vl_last ? hi_q[2:0] : 3'd7;

  always_comb begin
    st_d    = st_q;
    cur_d   = cur_q;
    hi_d    = hi_q;
    fix_d   = fix_q;
    clr_d   = clr_q;
    q_pop_o = 1'b0;
    a_valid = 1'b0;
    a_unit  = U_DRAW;
    a_addr  = '0;
    a_mask  = '0;
    unique case (st_q)
      BK_INIT, BK_CLEAR: begin
        a_valid = 1'b1;
        a_unit  = U_CLEAR;
        a_addr  = clr_q;
        clr_d   = clr_q + ADDR_W'(1);
        if (clr_q == AddrLast) begin
          clr_d = '0;
          st_d  = BK_IDLE;
        end
      end
      BK_IDLE: begin
        if (!q_empty_i) begin
          unique case (q_head_i.code)
            OP_HLINE, OP_VLINE: begin
              q_pop_o = 1'b1;
              st_d    = (q_head_i.code == OP_HLINE) ? BK_HLINE : BK_VLINE;
              cur_d   = q_head_i.lo;
              hi_d    = q_head_i.hi;
              fix_d   = q_head_i.fix;
            end
            OP_CLEAR: begin
              q_pop_o = 1'b1;
              clr_d   = '0;
              st_d    = BK_CLEAR;
            end
            OP_READ, OP_READ_OOR: begin
              if (read_free) begin
                q_pop_o = 1'b1;
                a_valid = 1'b1;
                a_unit  = (q_head_i.code == OP_READ) ? U_READ : U_READ_OOR;
                a_addr  = page_addr(q_head_i.fix, q_head_i.lo[7:3]);
              end
            end
            default: q_pop_o = 1'b1;
          endcase
        end
      end
      BK_HLINE: begin
        a_valid = 1'b1;
        a_addr  = page_addr(cur_q, fix_q[7:3]);
        a_mask  = 8'd1 << fix_q[2:0];
        cur_d   = cur_q + 8'd1;
        if (cur_q == hi_q) begin
          st_d = BK_IDLE;
        end
      end
      BK_VLINE: begin
        // One unit covers every row of the line that falls in this page.
        a_valid = 1'b1;
        a_addr  = page_addr(fix_q, cur_q[7:3]);
        a_mask  = (8'hFF << cur_q[2:0]) & (8'hFF >> (3'd7 - vl_end));
        cur_d   = {cur_q[7:3] + 5'd1, 3'b000};
        if (vl_last) begin
          st_d = BK_IDLE;
        end
      end
      default: st_d = BK_IDLE;
    endcase
  end

  // Write-back: data of the unit issued last cycle, with a bypass for a read
  // that met a write to the same byte in the same cycle.
  assign base      = fwd_q ? fwd_data_q : ram_rdata;
  assign ram_we    = b_valid_q && ((b_unit_q == U_DRAW) || (b_unit_q == U_CLEAR));
  assign ram_wdata = (b_unit_q == U_CLEAR) ? 8'h00 : (base | b_mask_q);

  always_comb begin
    out_valid_d = out_valid_q && !out_ready_i;
    out_d       = out_q;
    if (b_is_read) begin
      out_valid_d = 1'b1;
      if (b_unit_q == U_READ) begin
        out_d.read_byte    = base;
        out_d.out_of_range = 1'b0;
      end else begin
        out_d.read_byte    = 8'h00;
        out_d.out_of_range = 1'b1;
      end
    end
  end

  fbde_ram #(
    .WIDTH(8),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(b_addr_q),
    .wdata_i(ram_wdata),
    .raddr_i(a_addr),
    .rdata_o(ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= BK_INIT;
      clr_q       <= '0;
      b_valid_q   <= 1'b0;
      fwd_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      st_q        <= st_d;
      clr_q       <= clr_d;
      b_valid_q   <= a_valid;
      fwd_q       <= ram_we && (b_addr_q == a_addr);
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q      <= cur_d;
    hi_q       <= hi_d;
    fix_q      <= fix_d;
    b_unit_q   <= a_unit;
    b_addr_q   <= a_addr;
    b_mask_q   <= a_mask;
    fwd_data_q <= ram_wdata;
    out_q      <= out_d;
  end

  assign init_busy_o = (st_q == BK_INIT);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `ASSERT_NEVER(bk_result_slot_free, clk_i, rst_ni, b_is_read && out_valid_q)
  `ASSERT_CLK(bk_init_holds_queue, clk_i, rst_ni, (st_q == BK_INIT) |-> !q_pop_o)

endmodule

// ----- verif/tb.sv -----
// ---------------------------------------------------------------------------
// tb
// Self-checking bench for the page framebuffer drawing engine. Commands are
// pushed through the input channel while a scoreboard keeps its own copy of
// the page store. Every read back is compared with the predicted page byte.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
  import fbde_pkg::*;

  // The two command codes that the engine must ignore.
  localparam logic [2:0] KIND_SPARE_A = 3'd6;
  localparam logic [2:0] KIND_SPARE_B = 3'd7;

  // Cycles with no accepted transaction on either channel before the run is
  // abandoned. The slowest legal stretch is a clear in progress with four
  // more clears queued behind it; this limit leaves a wide margin over it.
  localparam int IDLE_LIMIT   = 20000;
  // Settling time after the last read has returned: enough for the queue to
  // drain even if it is full of clears.
  localparam int DRAIN_CYCLES = 6000;
  localparam int RANDOM_ITEMS = 680;

  // -------------------------------------------------------------------------
  // Scoreboard: shadow copy of the page store plus the queue of read results
  // that are still owed by the engine.
  // -------------------------------------------------------------------------
  class page_scoreboard;
    bit [7:0]    pages [DEPTH];
    result_t     owed_reads [$];
    int unsigned mismatches;

    function new();
      mismatches = 0;
      foreach (pages[i]) pages[i] = 8'h00;
    endfunction

    function void flag(string msg);
      mismatches++;
      if (mismatches <= 10) $display("%s", msg);
    endfunction

    // Pixels outside the picture are clipped silently.
    function void plot(int x, int y);
      if (x < COLUMNS && y < ROWS) pages[x * PAGES + y / 8] |= 8'(1 << (y % 8));
    endfunction

    function void draw_row(int x0, int y, int x1);
      for (int x = x0; x <= x1; x++) plot(x, y);
    endfunction

    function void draw_column(int x, int y0, int y1);
      for (int y = y0; y <= y1; y++) plot(x, y);
    endfunction

    function void note_command(cmd_t c);
      result_t r;
      r = '0;
      case (c.kind)
        KIND_PIXEL: plot(c.x_start, c.y_start);
        KIND_HLINE: draw_row(c.x_start, c.y_start, c.x_end);
        KIND_VLINE: draw_column(c.x_start, c.y_start, c.y_end);
        KIND_RECT: begin
          draw_row(c.x_start, c.y_start, c.x_end);
          draw_row(c.x_start, c.y_end, c.x_end);
          draw_column(c.x_start, c.y_start, c.y_end);
          draw_column(c.x_end, c.y_start, c.y_end);
        end
        KIND_CLEAR: foreach (pages[i]) pages[i] = 8'h00;
        KIND_READ: begin
          if (c.x_start < COLUMNS && c.y_start < ROWS) begin
            r.read_byte = pages[int'(c.x_start) * PAGES + int'(c.y_start) / 8];
          end else begin
            r.out_of_range = 1'b1;
          end
          owed_reads.push_back(r);
        end
        default: ;
      endcase
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (owed_reads.size() == 0) begin
        flag($sformatf("unexpected result: byte %02h out_of_range %0d",
                       got.read_byte, got.out_of_range));
      end else begin
        want = owed_reads.pop_front();
        if (got.read_byte !== want.read_byte || got.out_of_range !== want.out_of_range) begin
          flag($sformatf("read mismatch: expected byte %02h out_of_range %0d, got %02h %0d",
                         want.read_byte, want.out_of_range, got.read_byte,
                         got.out_of_range));
        end
      end
    endfunction

    function int outstanding();
      return owed_reads.size();
    endfunction

    function void close_out();
      if (owed_reads.size() != 0)
        flag($sformatf("%0d reads never returned", owed_reads.size()));
    endfunction
  endclass

  logic    clk_i;
  logic    rst_ni;
  logic    in_valid_i;
  logic    in_ready_o;
  cmd_t    in_data_i;
  logic    out_valid_o;
  logic    out_ready_i;
  result_t out_data_o;

  page_scoreboard sb = new();
  int unsigned    idle_cycles;
  logic [7:0]     last_x;
  logic [7:0]     last_y;

  page_framebuffer_draw_engine_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // Gap lengths: none half the time, so that back-to-back stretches occur,
  // often short, and now and then a long pause.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // A coordinate that usually lies inside the picture, sometimes hugs the
  // border on either side, and sometimes uses the whole 8-bit range.
  function automatic logic [7:0] pick_coord(int span);
    int r;
    r = $urandom_range(0, 99);
    if (r < 75) return 8'($urandom_range(0, span - 1));
    if (r < 88) return 8'($urandom_range(span - 2, span + 1));
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic cmd_t make_cmd(logic [2:0] k, logic [7:0] xs, logic [7:0] ys,
                                    logic [7:0] xe, logic [7:0] ye);
    cmd_t c;
    c.kind    = k;
    c.x_start = xs;
    c.y_start = ys;
    c.x_end   = xe;
    c.y_end   = ye;
    return c;
  endfunction

  // Random command. Lines and rectangles are mostly well formed (start not
  // beyond end); reads often land on the last drawn start point so that
  // they see set bits rather than an empty page.
  function automatic cmd_t random_command();
    cmd_t       c;
    int         r;
    logic [7:0] a;
    logic [7:0] b;
    logic [7:0] p;
    logic [7:0] q;
    bit         ordered;
    c = '0;
    r = $urandom_range(0, 99);
    ordered = ($urandom_range(0, 99) < 85);
    a = pick_coord(COLUMNS);
    b = pick_coord(COLUMNS);
    p = pick_coord(ROWS);
    q = pick_coord(ROWS);
    if (ordered && b < a) begin
      c.x_start = b;
      c.x_end   = a;
    end else begin
      c.x_start = a;
      c.x_end   = b;
    end
    if (ordered && q < p) begin
      c.y_start = q;
      c.y_end   = p;
    end else begin
      c.y_start = p;
      c.y_end   = q;
    end
    if (r < 20)      c.kind = KIND_PIXEL;
    else if (r < 34) c.kind = KIND_HLINE;
    else if (r < 48) c.kind = KIND_VLINE;
    else if (r < 58) c.kind = KIND_RECT;
    else if (r < 60) c.kind = KIND_CLEAR;
    else if (r < 63) c.kind = $urandom_range(0, 1) ? KIND_SPARE_A : KIND_SPARE_B;
    else begin
      c.kind = KIND_READ;
      if ($urandom_range(0, 1)) begin
        c.x_start = last_x;
        c.y_start = last_y;
      end
    end
    if (r < 58) begin
      last_x = c.x_start;
      last_y = c.y_start;
    end
    return c;
  endfunction

  // Present one command after a random gap and hold it until the engine
  // takes the transaction. Valid is only lowered when a gap is wanted.
  task automatic send_command(cmd_t c);
    int gap;
    gap = pick_gap();
    repeat (gap) begin
      @(negedge clk_i);
      in_valid_i = 1'b0;
    end
    @(negedge clk_i);
    in_valid_i = 1'b1;
    in_data_i  = c;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  // Receiver back-pressure: bursts of readiness separated by random stalls.
  initial begin
    out_ready_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      repeat (pick_gap()) begin
        @(negedge clk_i);
        out_ready_i = 1'b0;
      end
      repeat ($urandom_range(1, 8)) begin
        @(negedge clk_i);
        out_ready_i = 1'b1;
      end
    end
  end

  // Monitor and watchdog. Both channels are sampled at the rising edge, at
  // which the inputs driven on the falling edge are long settled.
  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && in_ready_o) sb.note_command(in_data_i);
    if (rst_ni && out_valid_o && out_ready_i) sb.check_result(out_data_o);
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    int   sent;
    cmd_t c;
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    in_data_i   = '0;
    idle_cycles = 0;
    last_x      = 8'd0;
    last_y      = 8'd0;
    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed part. Single pixels at two corners and just past the edges,
    // with reads that check clipping and the out-of-range flag.
    send_command(make_cmd(KIND_PIXEL, 8'd0, 8'd0, 8'd0, 8'd0));
    send_command(make_cmd(KIND_PIXEL, 8'd127, 8'd63, 8'd255, 8'd255));
    send_command(make_cmd(KIND_PIXEL, 8'd128, 8'd5, 8'd0, 8'd0));
    send_command(make_cmd(KIND_PIXEL, 8'd5, 8'd64, 8'd0, 8'd0));
    send_command(make_cmd(KIND_PIXEL, 8'd255, 8'd255, 8'd255, 8'd255));
    send_command(make_cmd(KIND_READ, 8'd0, 8'd0, 8'd255, 8'd255));
    send_command(make_cmd(KIND_READ, 8'd127, 8'd63, 8'd0, 8'd0));
    send_command(make_cmd(KIND_READ, 8'd128, 8'd5, 8'd0, 8'd0));
    send_command(make_cmd(KIND_READ, 8'd5, 8'd64, 8'd0, 8'd0));
    send_command(make_cmd(KIND_READ, 8'd255, 8'd255, 8'd0, 8'd0));
    // A full-width line clipped on the right, and a reversed one that must
    // leave the store untouched.
    send_command(make_cmd(KIND_HLINE, 8'd0, 8'd9, 8'd255, 8'd0));
    send_command(make_cmd(KIND_READ, 8'd64, 8'd9, 8'd0, 8'd0));
    send_command(make_cmd(KIND_HLINE, 8'd50, 8'd20, 8'd10, 8'd77));
    send_command(make_cmd(KIND_READ, 8'd30, 8'd20, 8'd0, 8'd0));
    // The same for vertical lines.
    send_command(make_cmd(KIND_VLINE, 8'd3, 8'd0, 8'd200, 8'd255));
    send_command(make_cmd(KIND_READ, 8'd3, 8'd40, 8'd0, 8'd0));
    send_command(make_cmd(KIND_VLINE, 8'd4, 8'd30, 8'd99, 8'd10));
    send_command(make_cmd(KIND_READ, 8'd4, 8'd20, 8'd0, 8'd0));
    // A plain rectangle, and one reversed in x whose horizontal edges vanish
    // while its two vertical edges are still drawn.
    send_command(make_cmd(KIND_RECT, 8'd10, 8'd30, 8'd20, 8'd40));
    send_command(make_cmd(KIND_READ, 8'd10, 8'd35, 8'd0, 8'd0));
    send_command(make_cmd(KIND_RECT, 8'd100, 8'd50, 8'd90, 8'd60));
    send_command(make_cmd(KIND_READ, 8'd90, 8'd55, 8'd0, 8'd0));
    send_command(make_cmd(KIND_READ, 8'd95, 8'd50, 8'd0, 8'd0));
    // Unused codes do nothing; a clear wipes everything drawn so far.
    send_command(make_cmd(KIND_SPARE_A, 8'd0, 8'd0, 8'd255, 8'd255));
    send_command(make_cmd(KIND_SPARE_B, 8'd3, 8'd9, 8'd3, 8'd9));
    send_command(make_cmd(KIND_CLEAR, 8'd255, 8'd255, 8'd255, 8'd255));
    send_command(make_cmd(KIND_READ, 8'd64, 8'd9, 8'd0, 8'd0));

    // Random part. Ignored codes are sent but not counted.
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      c = random_command();
      send_command(c);
      if (c.kind != KIND_SPARE_A && c.kind != KIND_SPARE_B) sent++;
    end
    @(negedge clk_i);
    in_valid_i = 1'b0;

    // Wait for the owed reads, then let any queued drawing work finish.
    while (sb.outstanding() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    sb.close_out();
    if (sb.mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
